[hdl/ps2h_pkg.sv]
package ps2h_pkg;

   localparam logic [1:0] ACT_EDGE    = 2'd0;
   localparam logic [1:0] ACT_WRITE   = 2'd1;
   localparam logic [1:0] ACT_POP     = 2'd2;
   localparam logic [1:0] ACT_RESTART = 2'd3;

   localparam logic [1:0] MODE_ERROR = 2'd0;
   localparam logic [1:0] MODE_RX    = 2'd1;
   localparam logic [1:0] MODE_TX    = 2'd2;

   localparam logic [3:0] FRAME_START = 4'd11;
   localparam logic [3:0] POS_START   = 4'd11;
   localparam logic [3:0] POS_TX_PAR  = 4'd3;
   localparam logic [3:0] POS_TX_STOP = 4'd2;
   localparam logic [3:0] POS_RX_PAR  = 4'd2;
   localparam logic [3:0] POS_LAST    = 4'd1;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } fifo_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   function automatic logic odd_parity(input logic [7:0] b);
      return ~(^b);
   endfunction

endpackage

[hdl/ps2h_top.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  action, data_pin, write_byte
// rsp_      out        rsp_valid / rsp_stall  data_drive, read_byte, fifo_count, line_mode
//
// One beat per cycle sustained while rsp_stall is low. Line state and FIFO
// pointers update at accept, when the receive store read register and a hold
// stage also load; the output register follows, and rsp_valid rises when the
// hold stage moves into it. Synchronous reset clears control and pointers;
// store contents are not cleared. rsp_stall backs up through the hold stage
// into req_stall.
module ps2_host_frame_engine_top #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic                              req_data_pin,
   input  logic [7:0]                        req_write_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_data_drive,
   output logic [7:0]                        rsp_read_byte,
   output logic [$clog2(FIFO_DEPTH+1)-1:0]   rsp_fifo_count,
   output logic [1:0]                        rsp_line_mode
);

   localparam int CW = $clog2(FIFO_DEPTH + 1);

   logic                    accept;
   ps2h_pkg::fifo_cmd_type  cmd;
   ps2h_pkg::fifo_stat_type stat;
   logic [CW-1:0]           count_next;
   logic [7:0]              rd_data;

   logic [1:0]    mode_ff, mode_in;
   logic [3:0]    bit_cnt_ff, bit_cnt_in;
   logic [7:0]    shift_ff, shift_in;
   logic          tx_par_ff, tx_par_in;
   logic          drive_ff, drive_in;

   logic          b_valid_ff;
   logic          b_drive_ff;
   logic          b_pop_ff;
   logic [CW-1:0] b_count_ff;
   logic [1:0]    b_mode_ff;
   logic          b_move;
   logic          c_free;

   logic          c_valid_ff;
   logic          c_drive_ff;
   logic [7:0]    c_byte_ff;
   logic [CW-1:0] c_count_ff;
   logic [1:0]    c_mode_ff;

   assign c_free    = !c_valid_ff || !rsp_stall;
   assign b_move    = b_valid_ff && c_free;
   assign req_stall = b_valid_ff && !c_free;
   assign accept    = req_valid && !req_stall;

   ps2h_rx_fifo #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_data  (shift_ff),
      .status     (stat),
      .count_next (count_next),
      .rd_data    (rd_data)
   );

   always_comb begin
      mode_in    = mode_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      tx_par_in  = tx_par_ff;
      drive_in   = drive_ff;
      cmd        = '0;
      if (accept) begin
         unique case (req_action)
            ps2h_pkg::ACT_EDGE: begin
               if (mode_ff != ps2h_pkg::MODE_ERROR) begin
                  bit_cnt_in = bit_cnt_ff - 1'b1;
                  if (mode_ff == ps2h_pkg::MODE_TX) begin
                     case (bit_cnt_ff)
                        ps2h_pkg::POS_TX_PAR:  drive_in = ~tx_par_ff;
                        ps2h_pkg::POS_TX_STOP: drive_in = 1'b0;
                        ps2h_pkg::POS_LAST: begin
                           mode_in    = req_data_pin ? ps2h_pkg::MODE_ERROR
                                                     : ps2h_pkg::MODE_RX;
                           bit_cnt_in = ps2h_pkg::FRAME_START;
                        end
                        default: begin
                           drive_in = ~shift_ff[0];
                           shift_in = {1'b0, shift_ff[7:1]};
                        end
                     endcase
                  end else begin
                     case (bit_cnt_ff)
                        ps2h_pkg::POS_START: begin
                           if (req_data_pin) mode_in = ps2h_pkg::MODE_ERROR;
                        end
                        ps2h_pkg::POS_RX_PAR: begin
                           if (ps2h_pkg::odd_parity(shift_ff) != req_data_pin) begin
                              mode_in = ps2h_pkg::MODE_ERROR;
                           end
                        end
                        ps2h_pkg::POS_LAST: begin
                           if (!req_data_pin || stat.full) begin
                              mode_in = ps2h_pkg::MODE_ERROR;
                           end else begin
                              cmd.push = 1'b1;
                           end
                           bit_cnt_in = ps2h_pkg::FRAME_START;
                        end
                        default: shift_in = {req_data_pin, shift_ff[7:1]};
                     endcase
                  end
               end
            end
            ps2h_pkg::ACT_WRITE: begin
               drive_in   = 1'b1;
               cmd.clear  = 1'b1;
               mode_in    = ps2h_pkg::MODE_TX;
               bit_cnt_in = ps2h_pkg::FRAME_START;
               shift_in   = req_write_byte;
               tx_par_in  = ps2h_pkg::odd_parity(req_write_byte);
            end
            ps2h_pkg::ACT_POP: cmd.pop = 1'b1;
            ps2h_pkg::ACT_RESTART: begin
               drive_in   = 1'b0;
               cmd.clear  = 1'b1;
               mode_in    = ps2h_pkg::MODE_RX;
               bit_cnt_in = ps2h_pkg::FRAME_START;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= ps2h_pkg::MODE_RX;
         bit_cnt_ff <= ps2h_pkg::FRAME_START;
         shift_ff   <= '0;
         tx_par_ff  <= 1'b0;
         drive_ff   <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         tx_par_ff  <= tx_par_in;
         drive_ff   <= drive_in;
         if (accept) begin
            b_valid_ff <= 1'b1;
         end else if (b_move) begin
            b_valid_ff <= 1'b0;
         end
         if (b_move) begin
            c_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            c_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_drive_ff <= drive_in;
         b_pop_ff   <= cmd.pop && !stat.empty;
         b_count_ff <= count_next;
         b_mode_ff  <= mode_in;
      end
      if (b_move) begin
         c_drive_ff <= b_drive_ff;
         c_byte_ff  <= b_pop_ff ? rd_data : 8'h00;
         c_count_ff <= b_count_ff;
         c_mode_ff  <= b_mode_ff;
      end
   end

   assign rsp_valid      = c_valid_ff;
   assign rsp_data_drive = c_drive_ff;
   assign rsp_read_byte  = c_byte_ff;
   assign rsp_fifo_count = c_count_ff;
   assign rsp_line_mode  = c_mode_ff;

endmodule

[hdl/ps2h_rx_fifo.sv]
module ps2h_rx_fifo #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ps2h_pkg::fifo_cmd_type            cmd,
   input  logic [7:0]                        push_data,
   output ps2h_pkg::fifo_stat_type           status,
   output logic [$clog2(FIFO_DEPTH+1)-1:0]   count_next,
   output logic [7:0]                        rd_data
);

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   logic [7:0]    store_mem [FIFO_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status.full  = (count_ff == CW'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = cmd.push && !status.full;
   assign do_pop       = cmd.pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (cmd.clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end else if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   assign count_next = count_in;
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push && !cmd.clear) begin
         store_mem[wr_ptr_ff] <= push_data;
      end
      if (do_pop && !cmd.clear) begin
         rd_data_ff <= store_mem[rd_ptr_ff];
      end
   end

endmodule
